[hw/rtl/boris_velocity_pusher_unit_assert.svh]
// assertion macros shared by the velocity pusher rtl
`ifndef BORIS_VELOCITY_PUSHER_UNIT_ASSERT_SVH
`define BORIS_VELOCITY_PUSHER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BVP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvp: same-cycle check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define BVP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvp: next-cycle check failed");

`endif

[hw/rtl/bvp_pkg.sv]
// types, constants and fixed-point helpers of the velocity pusher
package bvp_pkg;

    localparam int FRAC_BITS  = 20;
    // restoring divider for s: quotient bits and bits per stage
    localparam int DIV_QBITS  = 24;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_QBITS / DIV_STEPS;
    localparam int DVD_W      = 53;
    localparam int DSR_W      = 44;
    // square root: result bits and bits per stage
    localparam int SQ_BITS    = 32;
    localparam int SQ_STEPS   = 4;
    localparam int SQ_STAGES  = SQ_BITS / SQ_STEPS;

    localparam logic [30:0] GAMMA_MAX = 31'h7fffffff;
    localparam logic [31:0] QM_RESET  = 32'hfff00000;
    localparam logic [30:0] DT_RESET  = 31'h00080000;
    localparam logic [DIV_QBITS-1:0] S_MAG_MAX = DIV_QBITS'((1 << FRAC_BITS) + 1);
    localparam logic [30:0] GAMMA_ONE = 31'(1 << FRAC_BITS);

    typedef enum logic {
        REG_QM = 1'b0,
        REG_DT = 1'b1
    } reg_idx_t;

    typedef logic signed [31:0] q_t;
    typedef q_t [2:0] vec3_t;
    typedef logic signed [43:0] mq_t;

    typedef struct packed {
        vec3_t um;
        vec3_t up;
        vec3_t e;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [2:0]              neg;
        logic [2:0][DVD_W-1:0]   dvd;
        logic [DSR_W-1:0]        dsr;
    } div_in_t;

    typedef struct packed {
        side_t side;
        vec3_t s;
    } div_out_t;

    typedef struct packed {
        vec3_t       v;
        logic [63:0] x;
    } root_in_t;

    // clamp to the signed 32-bit range
    function automatic q_t sat32(input logic signed [47:0] x);
        q_t r;
        if (x > 48'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -48'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // q12.20 product, rounded to nearest with ties away from zero, no clamp
    function automatic mq_t mulq(input q_t a, input q_t b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = a * b;
        r = (p + 64'sd524288 - $signed({63'd0, p[63]})) >>> FRAC_BITS;
        return r[43:0];
    endfunction

endpackage

[hw/rtl/bvp_kick.sv]
// front stages: input beat, half kick, t vector, first rotation and divider setup
module bvp_kick
    import bvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  q_t          qm,
    input  logic [30:0] dt,
    input  logic        in_vld,
    input  vec3_t       u,
    input  vec3_t       ef,
    input  vec3_t       bf,
    output logic        out_vld,
    output div_in_t     dout
);

    logic signed [63:0] hk_prod;
    logic signed [63:0] hk_rnd;
    q_t                 hk_reg;

    logic [4:0] vld_reg;

    vec3_t s1_u_reg, s1_ef_reg, s1_bf_reg;
    vec3_t s2_u_reg, s2_e_reg, s2_t_reg;
    vec3_t s2_e_next, s2_t_next;
    vec3_t s3_um_reg, s3_e_reg, s3_t_reg;
    vec3_t s3_um_next;
    logic [2:0][63:0] s3_tsq_reg, s3_tsq_next;
    vec3_t s4_um_reg, s4_e_reg, s4_t_reg;
    mq_t [2:0][1:0] s4_m_reg, s4_m_next;
    logic [DSR_W-1:0] s4_d20_reg, s4_d20_next;
    div_in_t s5_reg, s5_next;

    // (q/m)*dt/2, follows the config registers every cycle
    assign hk_prod = qm * $signed({1'b0, dt});
    assign hk_rnd  = (hk_prod + 64'sd1048576 - $signed({63'd0, hk_prod[63]}))
                     >>> (FRAC_BITS + 1);

    always_ff @(posedge clk)
    begin
        hk_reg <= sat32(hk_rnd[47:0]);
    end

    always_comb
    begin
        logic signed [63:0] sq;
        logic [63:0]        dsum;
        int                 j;
        int                 k;
        q_t                 c;
        logic [31:0]        mag;
        for (int i = 0; i < 3; i++)
        begin
            s2_e_next[i] = sat32(mulq(hk_reg, s1_ef_reg[i]));
            s2_t_next[i] = sat32(mulq(hk_reg, s1_bf_reg[i]));
            s3_um_next[i] = sat32(48'($signed(s2_u_reg[i])) + 48'($signed(s2_e_reg[i])));
            sq = $signed(s2_t_reg[i]) * $signed(s2_t_reg[i]);
            s3_tsq_next[i] = sq;
        end
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            s4_m_next[i][0] = mulq(s3_um_reg[j], s3_t_reg[k]);
            s4_m_next[i][1] = mulq(s3_um_reg[k], s3_t_reg[j]);
        end
        // d = 2^40 + |t|^2, rounded to q.20
        dsum = s3_tsq_reg[0] + s3_tsq_reg[1] + s3_tsq_reg[2]
               + (64'd1 << (2 * FRAC_BITS)) + (64'd1 << (FRAC_BITS - 1));
        s4_d20_next = dsum[63:FRAC_BITS];

        s5_next.side.um = s4_um_reg;
        s5_next.side.e  = s4_e_reg;
        s5_next.dsr     = s4_d20_reg;
        for (int i = 0; i < 3; i++)
        begin
            c = sat32(48'($signed(s4_m_reg[i][0])) - 48'($signed(s4_m_reg[i][1])));
            s5_next.side.up[i] = sat32(48'($signed(s4_um_reg[i])) + 48'($signed(c)));
            mag = s4_t_reg[i][31] ? 32'(-s4_t_reg[i]) : s4_t_reg[i];
            s5_next.neg[i] = s4_t_reg[i][31];
            s5_next.dvd[i] = (DVD_W'(mag) << (FRAC_BITS + 1))
                             + DVD_W'(s4_d20_reg >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg   <= u;
            s1_ef_reg  <= ef;
            s1_bf_reg  <= bf;
            s2_u_reg   <= s1_u_reg;
            s2_e_reg   <= s2_e_next;
            s2_t_reg   <= s2_t_next;
            s3_um_reg  <= s3_um_next;
            s3_e_reg   <= s2_e_reg;
            s3_t_reg   <= s2_t_reg;
            s3_tsq_reg <= s3_tsq_next;
            s4_um_reg  <= s3_um_reg;
            s4_e_reg   <= s3_e_reg;
            s4_t_reg   <= s3_t_reg;
            s4_m_reg   <= s4_m_next;
            s4_d20_reg <= s4_d20_next;
            s5_reg     <= s5_next;
        end
    end

    assign out_vld = vld_reg[4];
    assign dout    = s5_reg;

endmodule

[hw/rtl/bvp_div.sv]
// pipelined restoring divider for the three s lanes
module bvp_div
    import bvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_vld,
    input  div_in_t  din,
    output logic     out_vld,
    output div_out_t dout
);

`include "boris_velocity_pusher_unit_assert.svh"

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0]                   vld_reg;
    logic [2:0][DSR_W-1:0]                   rem_reg [DIV_STAGES];
    logic [2:0][DIV_QBITS-1:0]               qd_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0][DSR_W-1:0]        dsr_reg;
    logic [DIV_STAGES-1:0][2:0]              neg_reg;
    side_t [DIV_STAGES-1:0]                  side_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [2:0][DSR_W-1:0]     rem_in;
        logic [2:0][DIV_QBITS-1:0] qd_in;
        logic [DSR_W-1:0]          dsr_in;
        logic [2:0][DSR_W-1:0]     rem_next;
        logic [2:0][DIV_QBITS-1:0] qd_next;

        if (g == 0)
        begin : g_first
            // the quotient is known to fit, so the top bits start as remainder
            always_comb
            begin
                for (int ln = 0; ln < 3; ln++)
                begin
                    rem_in[ln] = DSR_W'(din.dvd[ln] >> DIV_QBITS);
                    qd_in[ln]  = din.dvd[ln][DIV_QBITS-1:0];
                end
            end
            assign dsr_in = din.dsr;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign qd_in  = qd_reg[g-1];
            assign dsr_in = dsr_reg[g-1];
        end

        always_comb
        begin
            logic [DSR_W:0]         trial;
            logic [DSR_W-1:0]       rv;
            logic [DIV_QBITS-1:0]   qv;
            logic                   qb;
            for (int ln = 0; ln < 3; ln++)
            begin
                rv = rem_in[ln];
                qv = qd_in[ln];
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    trial = {rv, qv[DIV_QBITS-1]};
                    qb    = (trial >= {1'b0, dsr_in});
                    if (qb)
                    begin
                        trial = trial - {1'b0, dsr_in};
                    end
                    rv = trial[DSR_W-1:0];
                    qv = {qv[DIV_QBITS-2:0], qb};
                end
                rem_next[ln] = rv;
                qd_next[ln]  = qv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                qd_reg[g]  <= qd_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsr_reg  <= {dsr_reg[DIV_STAGES-2:0], din.dsr};
            neg_reg  <= {neg_reg[DIV_STAGES-2:0], din.neg};
            side_reg <= {side_reg[DIV_STAGES-2:0], din.side};
        end
    end

    always_comb
    begin
        q_t qs;
        dout.side = side_reg[LAST];
        for (int ln = 0; ln < 3; ln++)
        begin
            qs = $signed({{(32 - DIV_QBITS){1'b0}}, qd_reg[LAST][ln]});
            dout.s[ln] = neg_reg[LAST][ln] ? -qs : qs;
        end
    end

    assign out_vld = vld_reg[LAST];

    // |s| stays within one plus an lsb, as 2t/(1+t^2) never passes one
    `BVP_ASSERT_IMP(a_div_s_bound, out_vld, (qd_reg[LAST][0] <= S_MAG_MAX) && (qd_reg[LAST][1] <= S_MAG_MAX) && (qd_reg[LAST][2] <= S_MAG_MAX))
    `BVP_ASSERT_NXT(a_div_stall_hold, !en, $stable(qd_reg[LAST]) && $stable(rem_reg[LAST]))

endmodule

[hw/rtl/bvp_rotate.sv]
// second rotation, final half kick and |v|^2 for gamma
module bvp_rotate
    import bvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_vld,
    input  div_out_t din,
    output logic     out_vld,
    output root_in_t dout
);

    logic [3:0] vld_reg;

    mq_t [2:0][1:0]   r1_m_reg, r1_m_next;
    vec3_t            r1_um_reg, r1_e_reg;
    vec3_t            r2_v_reg, r2_v_next;
    logic [2:0][63:0] r3_vsq_reg, r3_vsq_next;
    vec3_t            r3_v_reg;
    root_in_t         r4_reg, r4_next;

    always_comb
    begin
        int                 j;
        int                 k;
        q_t                 c;
        q_t                 uq;
        logic signed [63:0] sq;
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            r1_m_next[i][0] = mulq(din.side.up[j], din.s[k]);
            r1_m_next[i][1] = mulq(din.side.up[k], din.s[j]);
        end
        for (int i = 0; i < 3; i++)
        begin
            c  = sat32(48'($signed(r1_m_reg[i][0])) - 48'($signed(r1_m_reg[i][1])));
            uq = sat32(48'($signed(r1_um_reg[i])) + 48'($signed(c)));
            r2_v_next[i] = sat32(48'($signed(uq)) + 48'($signed(r1_e_reg[i])));
            sq = $signed(r2_v_reg[i]) * $signed(r2_v_reg[i]);
            r3_vsq_next[i] = sq;
        end
        r4_next.v = r3_v_reg;
        r4_next.x = r3_vsq_reg[0] + r3_vsq_reg[1] + r3_vsq_reg[2]
                    + (64'd1 << (2 * FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_m_reg   <= r1_m_next;
            r1_um_reg  <= din.side.um;
            r1_e_reg   <= din.side.e;
            r2_v_reg   <= r2_v_next;
            r3_vsq_reg <= r3_vsq_next;
            r3_v_reg   <= r2_v_reg;
            r4_reg     <= r4_next;
        end
    end

    assign out_vld = vld_reg[3];
    assign dout    = r4_reg;

endmodule

[hw/rtl/bvp_isqrt.sv]
// pipelined integer square root for gamma, velocity carried alongside
module bvp_isqrt
    import bvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  root_in_t    din,
    output logic        out_vld,
    output logic [30:0] gamma,
    output vec3_t       vel
);

    localparam int LAST = SQ_STAGES - 1;

    logic [SQ_STAGES-1:0] vld_reg;
    logic [63:0]          x_reg   [SQ_STAGES];
    logic [63:0]          r_reg   [SQ_STAGES];
    vec3_t                vel_reg [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_stage
        logic [63:0] x_in;
        logic [63:0] r_in;
        vec3_t       v_in;
        logic [63:0] x_next;
        logic [63:0] r_next;

        if (g == 0)
        begin : g_first
            assign x_in = din.x;
            assign r_in = '0;
            assign v_in = din.v;
        end
        else
        begin : g_rest
            assign x_in = x_reg[g-1];
            assign r_in = r_reg[g-1];
            assign v_in = vel_reg[g-1];
        end

        // one result bit a step, trial bit walks down by powers of four
        always_comb
        begin
            logic [63:0] xv;
            logic [63:0] rv;
            logic [63:0] bv;
            xv = x_in;
            rv = r_in;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                bv = 64'd1 << (2 * SQ_BITS - 2 - 2 * (g * SQ_STEPS + k));
                if (xv >= rv + bv)
                begin
                    xv = xv - (rv + bv);
                    rv = (rv >> 1) + bv;
                end
                else
                begin
                    rv = rv >> 1;
                end
            end
            x_next = xv;
            r_next = rv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]   <= x_next;
                r_reg[g]   <= r_next;
                vel_reg[g] <= v_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQ_STAGES-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[LAST];
    assign gamma   = (r_reg[LAST] > 64'(GAMMA_MAX)) ? GAMMA_MAX : r_reg[LAST][30:0];
    assign vel     = vel_reg[LAST];

endmodule

[hw/rtl/boris_velocity_pusher_unit.sv]
// top level of the relativistic boris velocity pusher
//
// Streams one particle per beat: velocity u, fields E and B in, new velocity and
// gamma out, velocities signed q12.20 and gamma unsigned q11.20, with saturation.
// One beat can enter every clock while in_ready is high. The pipeline is made of
// 5 front stages, 12 divider stages, 4 rotation stages and 8 square-root stages;
// its depth is set by the restoring divider that forms s = 2t/(1+|t|^2), two
// quotient bits a stage over 24 bits, and by the gamma square root, four result
// bits a stage over 32 bits. The pipeline advances as a whole: when a result
// sits on the output with out_ready low, every stage holds and in_ready drops in
// the same cycle. The user writes charge_over_mass and time_step through the cfg
// port only while no beat is in flight; the block does not enforce it. The derived
// factor (q/m)*dt/2 is registered and settles before any following beat uses it.
module boris_velocity_pusher_unit
    import bvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // particle in
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] vel_x_in,
    input  logic [31:0] vel_y_in,
    input  logic [31:0] vel_z_in,
    input  logic [31:0] efield_x,
    input  logic [31:0] efield_y,
    input  logic [31:0] efield_z,
    input  logic [31:0] bfield_x,
    input  logic [31:0] bfield_y,
    input  logic [31:0] bfield_z,
    // particle out
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] gamma_out,
    output logic [31:0] vel_x_out,
    output logic [31:0] vel_y_out,
    output logic [31:0] vel_z_out
);

`include "boris_velocity_pusher_unit_assert.svh"

    // config registers
    logic [31:0] qm_reg;
    logic [30:0] dt_reg;

    // global advance: the output stage is empty or being drained
    logic en;

    vec3_t    u_in, e_in, b_in;
    logic     kick_vld, div_vld, rot_vld;
    div_in_t  kick_data;
    div_out_t div_data;
    root_in_t rot_data;
    vec3_t    vel_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qm_reg <= QM_RESET;
            dt_reg <= DT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_QM: qm_reg <= cfg_wdata;
                REG_DT: dt_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // component order x, y, z at index 0, 1, 2
    assign u_in = {vel_z_in, vel_y_in, vel_x_in};
    assign e_in = {efield_z, efield_y, efield_x};
    assign b_in = {bfield_z, bfield_y, bfield_x};

    // half kick, t, first rotation, divider operands
    bvp_kick u_kick (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .qm      ($signed(qm_reg)),
        .dt      (dt_reg),
        .in_vld  (in_valid),
        .u       (u_in),
        .ef      (e_in),
        .bf      (b_in),
        .out_vld (kick_vld),
        .dout    (kick_data)
    );

    // s = 2t/(1+|t|^2), three lanes
    bvp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (kick_vld),
        .din     (kick_data),
        .out_vld (div_vld),
        .dout    (div_data)
    );

    // second rotation, second half kick, 1+|v|^2
    bvp_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (div_vld),
        .din     (div_data),
        .out_vld (rot_vld),
        .dout    (rot_data)
    );

    // gamma; its last stage is the output register
    bvp_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (rot_vld),
        .din     (rot_data),
        .out_vld (out_valid),
        .gamma   (gamma_out),
        .vel     (vel_res)
    );

    assign vel_x_out = vel_res[0];
    assign vel_y_out = vel_res[1];
    assign vel_z_out = vel_res[2];

    // gamma is never below one
    `BVP_ASSERT_IMP(a_gamma_at_least_one, out_valid, gamma_out >= GAMMA_ONE)
    // a particle at rest has gamma exactly one
    `BVP_ASSERT_IMP(a_gamma_at_rest, out_valid && (vel_x_out == '0) && (vel_y_out == '0) && (vel_z_out == '0), gamma_out == GAMMA_ONE)

endmodule
